// File: hw/rtl/ngph_pkg.sv
package ngph_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = 5;
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;
    localparam logic signed [CW-1:0] Q30_ONE  = 34'sd1073741824;

    // ceil(2^34 / 45), exact floor division by 45 for operands below 2^28
    localparam logic [28:0] RECIP_45    = 29'd381774871;
    localparam int          RECIP_SHIFT = 34;

    // register indexes of the configuration port
    localparam logic [0:0] REG_TARGET_LAT = 1'b0;
    localparam logic [0:0] REG_TARGET_LON = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANG,
        ST_ROT,
        ST_SQ,
        ST_CC,
        ST_CLAMP,
        ST_CCMUL,
        ST_SUM,
        ST_OUT
    } state_t;

    // CORDIC arctangent table, binary angle with 2^32 per turn
    function automatic logic [29:0] atan_turns(input logic [STEP_W-1:0] i);
        logic [29:0] r;
        begin
            case (i)
                5'd0:  r = 30'h20000000;
                5'd1:  r = 30'h12E4051E;
                5'd2:  r = 30'h09FB385B;
                5'd3:  r = 30'h051111D4;
                5'd4:  r = 30'h028B0D43;
                5'd5:  r = 30'h0145D7E1;
                5'd6:  r = 30'h00A2F61E;
                5'd7:  r = 30'h00517C55;
                5'd8:  r = 30'h0028BE53;
                5'd9:  r = 30'h00145F2F;
                5'd10: r = 30'h000A2F98;
                5'd11: r = 30'h000517CC;
                5'd12: r = 30'h00028BE6;
                5'd13: r = 30'h000145F3;
                5'd14: r = 30'h0000A2FA;
                5'd15: r = 30'h0000517D;
                5'd16: r = 30'h000028BE;
                5'd17: r = 30'h0000145F;
                5'd18: r = 30'h00000A30;
                5'd19: r = 30'h00000518;
                5'd20: r = 30'h0000028C;
                5'd21: r = 30'h00000146;
                5'd22: r = 30'h000000A3;
                5'd23: r = 30'h00000051;
                5'd24: r = 30'h00000029;
                5'd25: r = 30'h00000014;
                5'd26: r = 30'h0000000A;
                5'd27: r = 30'h00000005;
                5'd28: r = 30'h00000003;
                5'd29: r = 30'h00000001;
                default: r = 30'h0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: hw/rtl/ngph_cordic.sv
// Rotation CORDIC, one micro-rotation per cycle; folds to +-1/4 turn first
module ngph_cordic
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [31:0]                     phase,
    output logic                            done,
    output logic signed [ngph_pkg::CW-1:0]  sin_out,
    output logic signed [ngph_pkg::CW-1:0]  cos_out
);

    logic                           busy_reg, busy_next;
    logic [ngph_pkg::STEP_W-1:0]    step_reg, step_next;
    logic                           flip_reg, flip_next;
    logic signed [ngph_pkg::CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0]             z_reg, z_next;
    logic                           done_reg, done_next;
    logic signed [33:0]             z0;
    logic signed [ngph_pkg::CW-1:0] xs, ys;
    logic signed [33:0]             at;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        done_next = 1'b0;
        z0        = {{2{phase[31]}}, phase};
        xs        = x_reg >>> step_reg;
        ys        = y_reg >>> step_reg;
        at        = {4'b0, ngph_pkg::atan_turns(step_reg)};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            x_next    = ngph_pkg::GAIN_INV;
            y_next    = '0;
            flip_next = 1'b0;
            z_next    = z0;
            if (z0 > 34'sd1073741824)
            begin
                z_next    = z0 - 34'sd2147483648;
                flip_next = 1'b1;
            end
            else if (z0 < -34'sd1073741824)
            begin
                z_next    = z0 + 34'sd2147483648;
                flip_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == ngph_pkg::STEP_W'(ngph_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign done    = done_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;

endmodule

// File: hw/rtl/nearest_grid_point_haversine.sv
// Nearest grid point search by haversine term. Configure target_lat (index 0)
// and target_lon (index 1), then stream points; a competing point keeps the
// input not ready from its beat through four passes of a 30-step CORDIC
// (dlat/2, dlon/2, target and point latitude), each with its angle set-up,
// two squaring steps, then cosine product, clamp, multiply, sum and compare;
// the beat is taken in the idle state. A point past MAX_POINTS in a pass goes
// from idle straight to the compare step. On a beat with tlast the block
// emits the index and term of the first smallest term, then clears; a final
// point waits in the compare step while the previous result is still held.
module nearest_grid_point_haversine
#(
    parameter int MAX_POINTS = 1048576
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // point_lat[23:0], point_lon[48:24], zero pad
    input  logic        s_axis_tlast,   // last_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // best_index[19:0], best_term[51:20], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    ngph_pkg::state_t state_reg, state_next;

    logic signed [23:0] tlat_reg;
    logic signed [24:0] tlon_reg;
    logic signed [23:0] plat_reg;
    logic signed [24:0] plon_reg;
    logic               last_reg;
    logic [31:0]        min_term_reg;
    logic [CNT_W-1:0]   min_index_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [1:0]         pass_reg, pass_next;
    logic               go_reg, go_next;
    logic [31:0]        phase_reg;
    logic [32:0]        s2lat_reg, s2lon_reg;
    logic signed [33:0] c1_reg;
    logic signed [67:0] prod_reg;
    logic signed [33:0] cc_reg;
    logic signed [33:0] dterm_reg;
    logic [31:0]        h_reg;
    logic               out_valid_reg;
    logic [19:0]        out_index_reg;
    logic [31:0]        out_term_reg;

    logic               cdone;
    logic signed [33:0] csin, ccos;

    // angle conversion: round(|a| * 65536 / div), sign applied
    logic signed [26:0] ang;
    logic [25:0]        mag;
    logic [27:0]        yv;
    logic [31:0]        base;
    logic [56:0]        yprod;
    logic [31:0]        q;
    logic               half;
    logic [33:0]        sabs;
    logic [67:0]        sq;
    logic [40:0]        sqr;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;
    logic signed [67:0] cc_full;
    logic signed [33:0] sum;
    logic               accept;
    logic               active;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign active = (cnt_reg < CNT_W'(MAX_POINTS));

    // 65536/720 = 91 + 1/45, so q = 91*|a| + floor((|a| + 22) / 45);
    // full angles double both terms
    always_comb
    begin
        case (pass_reg)
            2'd0:    begin ang = 27'(plat_reg) - 27'(tlat_reg); half = 1'b1; end
            2'd1:    begin ang = 27'(plon_reg) - 27'(tlon_reg); half = 1'b1; end
            2'd2:    begin ang = 27'(tlat_reg); half = 1'b0; end
            default: begin ang = 27'(plat_reg); half = 1'b0; end
        endcase
        mag = ang[26] ? 26'(-ang) : 26'(ang);
        if (half)
        begin
            yv   = 28'(mag) + 28'd22;
            base = 32'(mag) * 32'd91;
        end
        else
        begin
            yv   = {1'b0, mag, 1'b0} + 28'd22;
            base = 32'(mag) * 32'd182;
        end
        yprod = 57'(yv) * 57'(ngph_pkg::RECIP_45);
        q     = base + 32'(yprod[56:ngph_pkg::RECIP_SHIFT]);
        if (ang[26])
        begin
            q = 32'(0) - q;
        end
    end

    ngph_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (go_reg),
        .phase   (phase_reg),
        .done    (cdone),
        .sin_out (csin),
        .cos_out (ccos)
    );

    // shared multiplier
    always_comb
    begin
        sabs  = csin[33] ? 34'(-csin) : 34'(csin);
        mul_a = $signed(sabs);
        mul_b = $signed(sabs);
        if (state_reg == ngph_pkg::ST_CC)
        begin
            mul_a = c1_reg;
            mul_b = ccos;
        end
        else if (state_reg == ngph_pkg::ST_CCMUL)
        begin
            mul_a = cc_reg;
            mul_b = $signed({1'b0, s2lon_reg});
        end
        mul_p   = mul_a * mul_b;
        sq      = 68'(mul_p);
        sqr     = 41'((sq + 68'd134217728) >> 28);
        cc_full = prod_reg >>> 30;
        sum     = $signed({1'b0, s2lat_reg}) + dterm_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        go_next    = 1'b0;
        case (state_reg)
            ngph_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pass_next  = 2'd0;
                    state_next = active ? ngph_pkg::ST_ANG : ngph_pkg::ST_OUT;
                end
            end
            ngph_pkg::ST_ANG:
            begin
                go_next    = 1'b1;
                state_next = ngph_pkg::ST_ROT;
            end
            ngph_pkg::ST_ROT:
            begin
                if (cdone)
                begin
                    case (pass_reg)
                        2'd0, 2'd1: state_next = ngph_pkg::ST_SQ;
                        2'd2:
                        begin
                            pass_next  = 2'd3;
                            state_next = ngph_pkg::ST_ANG;
                        end
                        default: state_next = ngph_pkg::ST_CC;
                    endcase
                end
            end
            ngph_pkg::ST_SQ:
            begin
                pass_next  = pass_reg + 2'd1;
                state_next = ngph_pkg::ST_ANG;
            end
            ngph_pkg::ST_CC:    state_next = ngph_pkg::ST_CLAMP;
            ngph_pkg::ST_CLAMP: state_next = ngph_pkg::ST_CCMUL;
            ngph_pkg::ST_CCMUL: state_next = ngph_pkg::ST_SUM;
            ngph_pkg::ST_SUM:   state_next = ngph_pkg::ST_OUT;
            ngph_pkg::ST_OUT:
            begin
                if (!last_reg || !out_valid_reg)
                begin
                    state_next = ngph_pkg::ST_IDLE;
                end
            end
            default: state_next = ngph_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ngph_pkg::ST_IDLE;
            pass_reg      <= 2'd0;
            go_reg        <= 1'b0;
            tlat_reg      <= '0;
            tlon_reg      <= '0;
            min_term_reg  <= '1;
            min_index_reg <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            go_reg    <= go_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ngph_pkg::REG_TARGET_LAT)
                begin
                    tlat_reg <= cfg_data[23:0];
                end
                else
                begin
                    tlon_reg <= cfg_data;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            // compare and, on the final beat, emit and clear
            if (state_reg == ngph_pkg::ST_OUT && !(last_reg && out_valid_reg))
            begin
                if (active && (pass_reg == 2'd3) && !last_reg)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (last_reg)
                begin
                    out_valid_reg <= 1'b1;
                    min_term_reg  <= '1;
                    min_index_reg <= '0;
                    cnt_reg       <= '0;
                    if (active && (pass_reg == 2'd3) && (h_reg < min_term_reg))
                    begin
                        out_index_reg <= 20'(cnt_reg);
                        out_term_reg  <= h_reg;
                    end
                    else
                    begin
                        out_index_reg <= 20'(min_index_reg);
                        out_term_reg  <= min_term_reg;
                    end
                end
                else if (active && (pass_reg == 2'd3) && (h_reg < min_term_reg))
                begin
                    min_term_reg  <= h_reg;
                    min_index_reg <= cnt_reg;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plat_reg <= s_axis_tdata[23:0];
            plon_reg <= s_axis_tdata[48:24];
            last_reg <= s_axis_tlast;
        end
        if (state_reg == ngph_pkg::ST_ANG)
        begin
            phase_reg <= q;
        end
        if (state_reg == ngph_pkg::ST_SQ)
        begin
            if (pass_reg == 2'd0)
            begin
                s2lat_reg <= (sqr > 41'h100000000) ? 33'h100000000 : 33'(sqr);
            end
            else
            begin
                s2lon_reg <= (sqr > 41'h100000000) ? 33'h100000000 : 33'(sqr);
            end
        end
        if (state_reg == ngph_pkg::ST_ROT && cdone && pass_reg == 2'd2)
        begin
            c1_reg <= ccos;
        end
        if (state_reg == ngph_pkg::ST_CC)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ngph_pkg::ST_CCMUL)
        begin
            dterm_reg <= 34'(mul_p >>> 30);
        end
        if (state_reg == ngph_pkg::ST_SUM)
        begin
            h_reg <= sum[33] ? 32'd0 : (sum[32] ? 32'hFFFFFFFF : sum[31:0]);
        end
    end

    // clamp of the cosine product, registered in front of the multiplier
    always_ff @(posedge clk)
    begin
        if (cc_full > 68'sd1073741824)
        begin
            cc_reg <= ngph_pkg::Q30_ONE;
        end
        else if (cc_full < -68'sd1073741824)
        begin
            cc_reg <= -ngph_pkg::Q30_ONE;
        end
        else
        begin
            cc_reg <= 34'(cc_full);
        end
    end

    assign s_axis_tready = (state_reg == ngph_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_term_reg, out_index_reg};

endmodule

// File: dv/ngph_checker.sv
`timescale 1ns / 100ps

// Watches the point, result and register channels, predicts the search result
// of every pass and compares it with what the block delivers.
module ngph_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // point_lat[23:0], point_lon[48:24], zero pad
    input  logic        s_axis_tlast,   // last_point
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // best_index[19:0], best_term[51:20], zero pad
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int     POINT_LIMIT = 1048576;
    localparam longint ONE_Q30     = 64'sd1 << 30;
    localparam longint ONE_Q32     = 64'sd1 << 32;
    localparam longint INV_GAIN    = 64'sd652032874;

    typedef struct packed {
        logic [19:0] index;
        logic [31:0] term;
    } search_result_t;

    // arctangent of 2^-i, 2^32 per turn
    localparam longint ARCTAN [30] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
        'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
    };

    logic [23:0]    tgt_lat;
    logic [24:0]    tgt_lon;
    logic [31:0]    kept_term;
    logic [19:0]    kept_index;
    int             points_seen;
    search_result_t best_q[$];

    // degrees * 65536 to binary angle; divisor 360 for full, 720 for half angles
    function automatic logic [31:0] deg_to_bin(input longint deg, input longint div);
        longint      mag;
        longint      q;
        logic [31:0] p;
        mag = (deg < 0) ? -deg : deg;
        q   = (mag * 65536 + div / 2) / div;
        p   = q[31:0];
        return (deg < 0) ? 32'(-p) : p;
    endfunction

    // rotation CORDIC, Q2.30 outputs, half-turn fold negates both
    function automatic void sincos(input logic [31:0] phase, output longint s,
                                   output longint c);
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        bit     flip;
        z    = longint'($signed(phase));
        flip = 0;
        x    = INV_GAIN;
        y    = 0;
        if (z > ONE_Q30)
        begin
            z    = z - (64'sd1 << 31);
            flip = 1;
        end
        else if (z < -ONE_Q30)
        begin
            z    = z + (64'sd1 << 31);
            flip = 1;
        end
        for (int i = 0; i < 30; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint sine_squared(input longint s);
        longint a;
        longint r;
        a = (s < 0) ? -s : s;
        r = (a * a + (64'sd1 << 27)) >>> 28;
        return (r > ONE_Q32) ? ONE_Q32 : r;
    endfunction

    function automatic logic [31:0] haversine_term(input longint plat, input longint plon);
        longint tlat;
        longint tlon;
        longint s;
        longint c;
        longint c1;
        longint c2;
        longint sq_lat;
        longint sq_lon;
        longint cc;
        longint sum;
        tlat = longint'($signed(tgt_lat));
        tlon = longint'($signed(tgt_lon));
        sincos(deg_to_bin(plat - tlat, 720), s, c);
        sq_lat = sine_squared(s);
        sincos(deg_to_bin(plon - tlon, 720), s, c);
        sq_lon = sine_squared(s);
        sincos(deg_to_bin(tlat, 360), s, c1);
        sincos(deg_to_bin(plat, 360), s, c2);
        cc = (c1 * c2) >>> 30;
        if (cc > ONE_Q30)
            cc = ONE_Q30;
        if (cc < -ONE_Q30)
            cc = -ONE_Q30;
        sum = sq_lat + ((cc * sq_lon) >>> 30);
        if (sum < 0)
            return 32'd0;
        if (sum > 64'sh0FFFFFFFF)
            return 32'hFFFFFFFF;
        return sum[31:0];
    endfunction

    assign pending = best_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_lat     <= '0;
            tgt_lon     <= '0;
            kept_term   <= '1;
            kept_index  <= '0;
            points_seen <= 0;
            errors      <= 0;
            best_q.delete();
        end
        else
        begin
            logic [31:0]    h;
            logic [31:0]    nterm;
            logic [19:0]    nidx;
            int             ncount;
            int             nerr;
            search_result_t got;
            search_result_t want;

            nerr = errors;

            // register write
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ngph_pkg::REG_TARGET_LAT)
                    tgt_lat <= cfg_data[23:0];
                else
                    tgt_lon <= cfg_data;
            end

            // point beat: update the running minimum
            if (s_axis_tvalid && s_axis_tready)
            begin
                nterm  = kept_term;
                nidx   = kept_index;
                ncount = points_seen;
                if (ncount < POINT_LIMIT)
                begin
                    h = haversine_term(longint'($signed(s_axis_tdata[23:0])),
                                       longint'($signed(s_axis_tdata[48:24])));
                    if (h < nterm)
                    begin
                        nterm = h;
                        nidx  = ncount[19:0];
                    end
                    ncount++;
                end
                if (s_axis_tlast)
                begin
                    best_q.push_back('{index: nidx, term: nterm});
                    nterm  = '1;
                    nidx   = '0;
                    ncount = 0;
                end
                kept_term   <= nterm;
                kept_index  <= nidx;
                points_seen <= ncount;
            end

            // result beat
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{index: m_axis_tdata[19:0], term: m_axis_tdata[51:20]};
                if (best_q.size() == 0)
                begin
                    $display("%0t: unexpected result index %0d term %h",
                             $time, got.index, got.term);
                    nerr++;
                end
                else
                begin
                    want = best_q.pop_front();
                    if (got.index !== want.index)
                    begin
                        $display("%0t: best_index expected %0d actual %0d",
                                 $time, want.index, got.index);
                        nerr++;
                    end
                    if (got.term !== want.term)
                    begin
                        $display("%0t: best_term expected %h actual %h",
                                 $time, want.term, got.term);
                        nerr++;
                    end
                end
            end

            errors <= nerr;
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int LAT_MAX = 5898240;
    localparam int LON_MAX = 11796480;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [24:0] cfg_data;
    int          errors;
    int          pending;

    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_req;

    nearest_grid_point_haversine dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    ngph_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    // result side: random stalls, and one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (3000)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // one point beat, with a random gap in front
    task automatic send_point(input logic [23:0] lat, input logic [24:0] lon,
                              input logic last);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20))
                @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, lon, lat};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [24:0] value);
        s_axis_tvalid <= 1'b0;
        cfg_valid     <= 1'b1;
        cfg_index     <= idx;
        cfg_data      <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // let every pending pass drain before touching the registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200)
            @(negedge clk);
    endtask

    // a point mostly inside the legal globe, sometimes any bit pattern
    task automatic random_point(output logic [23:0] lat, output logic [24:0] lon);
        if ($urandom_range(0, 9) == 0)
        begin
            lat = 24'($urandom);
            lon = 25'($urandom);
        end
        else
        begin
            lat = 24'(int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
            lon = 25'(int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
        end
    endtask

    // a run of passes of random length, repeats to provoke ties
    task automatic random_passes(input int n_points, input int max_len);
        logic [23:0] lat;
        logic [24:0] lon;
        int          left;
        left = 0;
        for (int i = 0; i < n_points; i++)
        begin
            if (left == 0)
                left = $urandom_range(1, max_len);
            if (i == 0 || $urandom_range(0, 7) != 0)
                random_point(lat, lon);
            left--;
            send_point(lat, lon, (left == 0) || (i == n_points - 1));
            if (i == n_points - 1)
                left = 0;
        end
    endtask

    logic [24:0] tgt_lat_set [6];
    logic [24:0] tgt_lon_set [6];

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = ngph_pkg::REG_TARGET_LAT;
        cfg_data      = '0;
        hold_req      = 1'b0;
        tx_idle_pct   = 15;
        rx_idle_pct   = 51;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: target at origin
        write_reg(ngph_pkg::REG_TARGET_LAT, 25'd0);
        write_reg(ngph_pkg::REG_TARGET_LON, 25'd0);
        send_point(24'd0, 25'd0, 1'b1);                         // single-point pass
        send_point(24'(LAT_MAX), 25'(LON_MAX), 1'b0);
        send_point(24'(-LAT_MAX), 25'(-LON_MAX), 1'b0);
        send_point(24'd65536, 25'd65536, 1'b0);
        send_point(24'd65536, 25'd65536, 1'b0);                 // tie: first stays
        send_point(24'd0, 25'(LON_MAX), 1'b1);
        send_point(24'h7FFFFF, 25'h0FFFFFF, 1'b0);              // beyond 90 degrees
        send_point(24'h800000, 25'h1000000, 1'b0);
        send_point(24'hFFFFFF, 25'h1FFFFFF, 1'b1);
        drain();

        // directed: target at a pole, points at or past the far pole and one on the target
        write_reg(ngph_pkg::REG_TARGET_LAT, 25'(-LAT_MAX));
        write_reg(ngph_pkg::REG_TARGET_LON, 25'(-LON_MAX));
        send_point(24'(LAT_MAX), 25'(LON_MAX), 1'b0);
        send_point(24'(LAT_MAX), 25'd0, 1'b0);
        send_point(24'h7FFFFF, 25'h0FFFFFF, 1'b1);
        send_point(24'(-LAT_MAX), 25'(-LON_MAX), 1'b0);
        send_point(24'(LAT_MAX), 25'(LON_MAX), 1'b1);
        drain();

        // register settings of the random part, extremes among them
        tgt_lat_set = '{25'd0, 25'(LAT_MAX), 25'(-LAT_MAX), 25'($urandom),
                        25'($urandom), 25'h1FFFFFF};
        tgt_lon_set = '{25'd0, 25'(LON_MAX), 25'(-LON_MAX), 25'($urandom),
                        25'($urandom), 25'h1000000};
        for (int k = 0; k < 6; k++)
        begin
            tx_idle_pct = (k < 2) ? 15 : (k < 4) ? 51 : 0;
            rx_idle_pct = (k < 2) ? 51 : (k < 4) ? 15 : 0;
            drain();
            write_reg(ngph_pkg::REG_TARGET_LAT, tgt_lat_set[k]);
            write_reg(ngph_pkg::REG_TARGET_LON, tgt_lon_set[k]);
            if (k == 2)
            begin
                // hold the result side off while single-point passes pile up
                hold_req = 1'b1;
                random_passes(12, 1);
            end
            random_passes(95, 12);
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (300)
            @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
